[sv/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/mbps_pkg.sv]
package mbps_pkg;

  // Window depth and register-backed pattern bytes
  localparam int unsigned PATTERN_MAX = 24;
  localparam int unsigned REG_BYTES   = 24;
  localparam int unsigned BYTE_W      = 8;

  localparam int unsigned LEN_W =
    $clog2(((PATTERN_MAX > REG_BYTES) ? PATTERN_MAX : REG_BYTES) + 1);
  localparam int unsigned RB_IDX_W = $clog2(REG_BYTES);

  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PLEN_W     = 5;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_MID  = 3'd1,
    REG_PAT_HIGH = 3'd2,
    REG_CARE     = 3'd3,
    REG_PLEN     = 3'd4,
    REG_BASE     = 3'd5,
    REG_SCAN_LEN = 3'd6
  } cfg_reg_e;

  // Per-cell compare setup: aligned pattern byte and its care bit
  typedef struct packed {
    logic              active;
    logic              cares;
    logic [BYTE_W-1:0] pat;
  } cell_cfg_t;

  // One result request
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] addr;
  } result_t;

endpackage

[sv/masked_byte_pattern_search_core.sv]
// Masked byte pattern search.
// Bytes enter on the s_axis channel, one per request; s_axis_tlast_i marks the
// final byte of a scan. Results leave on m_axis: tuser is the found flag, tdata
// the match address (base address plus start offset, zero when not found).
// A scan yields one result: the first match inside the scan length, or, on the
// last byte, a not-found result if nothing matched before.
// Pattern, care mask, length, base address and scan length are written on the
// cfg channel (index 0..6); cfg_ready_o is always high.
// Throughput: one byte per cycle while s_axis_tready_o is high. Each byte
// shifts through a row of window cells that all compare in parallel, so the
// window ending on the new byte is judged in the cycle the byte is accepted.
// A result is registered in the output slot before it shows on m_axis.
// When the receiver stalls, one more result is held in a skid slot; with both
// slots full s_axis_tready_o drops until the output slot drains.
// Reset clears the scan state and sets registers to zero, pattern length to 1.
// After the last byte the scan state clears by itself for the next scan.
module masked_byte_pattern_search_core import mbps_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [BYTE_W-1:0]     s_axis_tdata_i,   // data_byte[7:0]
  input  logic                  s_axis_tlast_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [ADDR_W-1:0]     m_axis_tdata_o,   // match_address[31:0]
  output logic                  m_axis_tuser_o,   // found[0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [CFG_DATA_W-1:0] pat_low_q, pat_mid_q, pat_high_q;
  logic [REG_BYTES-1:0]  care_q;
  logic [PLEN_W-1:0]     plen_q;
  logic [ADDR_W-1:0]     base_q;
  logic [CNT_W-1:0]      scan_len_q;

  // Scan state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  logic                    in_acc, cfg_acc;
  logic [LEN_W-1:0]        eff_len, len_m1;
  logic [3*CFG_DATA_W-1:0] pat_all;
  logic [BYTE_W-1:0]       pat_arr [REG_BYTES];
  logic [BYTE_W-1:0]       win [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]  ok;
  logic                    not_sat, enough, in_range, hit;
  logic [CNT_W-1:0]        start;
  logic                    push;
  result_t                 push_data, out_data;
  logic                    buf_ready;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_mid_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '0;
      plen_q     <= PLEN_W'(1);
      base_q     <= '0;
      scan_len_q <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        REG_PAT_MID:  pat_mid_q  <= cfg_data_i;
        REG_PAT_HIGH: pat_high_q <= cfg_data_i;
        REG_CARE:     care_q     <= cfg_data_i[REG_BYTES-1:0];
        REG_PLEN:     plen_q     <= cfg_data_i[PLEN_W-1:0];
        REG_BASE:     base_q     <= cfg_data_i[ADDR_W-1:0];
        REG_SCAN_LEN: scan_len_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp pattern length to 1..PATTERN_MAX
  always_comb begin
    if (plen_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(plen_q) > LEN_W'(PATTERN_MAX)) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = LEN_W'(plen_q);
    end
  end
  assign len_m1 = eff_len - LEN_W'(1);

  // Split pattern registers into bytes
  assign pat_all = {pat_high_q, pat_mid_q, pat_low_q};
  always_comb begin
    for (int b = 0; b < REG_BYTES; b++) begin
      pat_arr[b] = pat_all[b*BYTE_W +: BYTE_W];
    end
  end

  // Row of window cells; cell j holds the byte j places behind the newest
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    localparam logic [LEN_W-1:0] J = LEN_W'(j);
    logic [LEN_W-1:0]  pidx;
    logic [BYTE_W-1:0] byte_in;
    cell_cfg_t         ccfg;

    // Align the pattern to the window: cell j checks pattern byte len-1-j
    always_comb begin
      pidx        = eff_len - J - LEN_W'(1);
      ccfg.active = (J < eff_len);
      ccfg.cares  = 1'b0;
      ccfg.pat    = '0;
      if (pidx < LEN_W'(REG_BYTES)) begin
        ccfg.cares = care_q[pidx[RB_IDX_W-1:0]];
        ccfg.pat   = pat_arr[pidx[RB_IDX_W-1:0]];
      end
    end

    if (j == 0) begin : g_head
      assign byte_in = s_axis_tdata_i;
    end else begin : g_link
      assign byte_in = win[j-1];
    end

    mbps_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(in_acc),
      .byte_i (byte_in),
      .cfg_i  (ccfg),
      .byte_o (win[j]),
      .ok_o   (ok[j])
    );
  end

  // Judge the window that ends on the incoming byte
  assign not_sat  = ~&cnt_q;
  assign enough   = cnt_q >= CNT_W'(len_m1);
  assign start    = cnt_q - CNT_W'(len_m1);
  assign in_range = start < scan_len_q;
  assign hit      = not_sat && !done_q && enough && in_range && (&ok);

  assign push            = in_acc && (hit || (s_axis_tlast_i && !done_q));
  assign push_data.found = hit;
  assign push_data.addr  = hit ? (base_q + start) : '0;

  // Advance the byte counter and match flag; drop both after the last byte
  always_comb begin
    cnt_d  = cnt_q;
    done_d = done_q;
    if (in_acc) begin
      if (s_axis_tlast_i) begin
        cnt_d  = '0;
        done_d = 1'b0;
      end else begin
        cnt_d  = cnt_q + CNT_W'(not_sat);
        done_d = done_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Output slot with skid
  mbps_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .ready_o    (buf_ready),
    .valid_o    (m_axis_tvalid_o),
    .data_o     (out_data),
    .ready_i    (m_axis_tready_i)
  );

  assign s_axis_tready_o = buf_ready;
  assign m_axis_tdata_o  = out_data.addr;
  assign m_axis_tuser_o  = out_data.found;

endmodule

[sv/mbps_cell.sv]
module mbps_cell import mbps_pkg::*; (
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  cell_cfg_t         cfg_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              ok_o
);

  logic [BYTE_W-1:0] byte_q;

  // Hold one window byte, take the neighbor's byte on every accepted request
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

  // Compare the byte entering this cell; unused or wildcard positions pass
  assign ok_o = !cfg_i.active || !cfg_i.cares || (byte_i == cfg_i.pat);

endmodule

[sv/mbps_out_buf.sv]
module mbps_out_buf import mbps_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    ready_i
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, skid_data_q;
  logic    out_free;
  logic    load_out, out_from_skid, load_skid;

  assign out_free = !out_valid_q || ready_i;

  // Refill the output slot from the skid slot first, then from a new request
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    out_from_skid = 1'b0;
    load_skid     = 1'b0;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d   = 1'b1;
        load_out      = 1'b1;
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end else begin
        out_valid_d = push_i;
        load_out    = push_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      load_skid    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= out_from_skid ? skid_data_q : push_data_i;
    end
    if (load_skid) begin
      skid_data_q <= push_data_i;
    end
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

[sv/mbps_checker.sv]
`include "assert_macros.svh"

module mbps_checker import mbps_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [ADDR_W-1:0] m_axis_tdata_o,
  input logic              m_axis_tuser_o
);

  // A stalled result keeps its payload
  `ASSERT_AT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "stalled result changed")

  // A not-found result carries address zero
  `ASSERT_NEVER(a_miss_zero, clk_i, rst_ni,
    m_axis_tvalid_o && !m_axis_tuser_o && (m_axis_tdata_o != '0),
    "not-found result with nonzero address")

  // Input is held off only while a result waits at the output
  `ASSERT_NEVER(a_block_only_full, clk_i, rst_ni,
    !s_axis_tready_o && !m_axis_tvalid_o,
    "input blocked with empty output")

  // Input ready drops only after an output stall
  `ASSERT_AT(a_ready_fall, clk_i, rst_ni,
    $fell(s_axis_tready_o) |-> $past(m_axis_tvalid_o && !m_axis_tready_i),
    "input ready fell without output stall")

endmodule

bind masked_byte_pattern_search_core mbps_checker u_checker (.*);

[bench/masked_byte_pattern_search_core_tb.sv]
`timescale 1ns / 1ps

module masked_byte_pattern_search_core_tb import mbps_pkg::*;;

  localparam int unsigned TARGET_BYTES = 1750;
  localparam int unsigned PHASE_BYTES  = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned MAX_REPORTS  = 30;

  // Tracks the scan state and the search registers, and queues the result
  // that each accepted byte should produce.
  class match_tracker;
    logic [8*REG_BYTES-1:0] pat;
    logic [23:0]            care;
    logic [PLEN_W-1:0]      plen;
    logic [ADDR_W-1:0]      base;
    logic [31:0]            scan_len;
    logic [BYTE_W-1:0]      recent [PATTERN_MAX];
    logic [31:0]            seen;
    bit                     done;
    result_t                pending_matches [$];
    int unsigned            errors;
    int unsigned            hits;
    int unsigned            misses;

    function new();
      pat      = '0;
      care     = '0;
      plen     = PLEN_W'(1);
      base     = '0;
      scan_len = '0;
      errors   = 0;
      hits     = 0;
      misses   = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      foreach (recent[k]) recent[k] = '0;
      seen = '0;
      done = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PAT_LOW:  pat[63:0]    = val;
        REG_PAT_MID:  pat[127:64]  = val;
        REG_PAT_HIGH: pat[191:128] = val;
        REG_CARE:     care         = val[23:0];
        REG_PLEN:     plen         = val[PLEN_W-1:0];
        REG_BASE:     base         = val[ADDR_W-1:0];
        REG_SCAN_LEN: scan_len     = val[31:0];
        default: ;
      endcase
    endfunction

    // Zero length acts as one, anything past the window as the full window.
    function int unsigned eff_len();
      if (plen == 0) return 1;
      if (plen > PATTERN_MAX) return PATTERN_MAX;
      return plen;
    endfunction

    function bit window_hit(int unsigned len);
      int unsigned i;
      for (i = 0; i < len; i++) begin
        if (i < REG_BYTES && care[i] && recent[len-1-i] !== pat[i*8 +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] d, logic last);
      int unsigned len;
      int          k;
      logic [31:0] pos;
      logic [31:0] start;
      result_t     r;
      len = eff_len();
      for (k = PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = d;
      // A saturated counter shifts the byte in but judges no window.
      if (seen != 32'hFFFF_FFFF) begin
        pos  = seen;
        seen = seen + 1;
        if (!done && seen >= len) begin
          start = pos - (len - 1);
          if (start < scan_len && window_hit(len)) begin
            done    = 1'b1;
            r.found = 1'b1;
            r.addr  = base + start;
            pending_matches.push_back(r);
          end
        end
      end
      if (last) begin
        if (!done) begin
          r.found = 1'b0;
          r.addr  = '0;
          pending_matches.push_back(r);
        end
        clear_scan();
      end
    endfunction

    task flag_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_match(logic found, logic [ADDR_W-1:0] addr);
      result_t want;
      if (pending_matches.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: found=%0b addr=%h", found, addr));
        return;
      end
      want = pending_matches.pop_front();
      if (found !== want.found)
        flag_mismatch($sformatf("found=%0b, want %0b", found, want.found));
      if (addr !== want.addr)
        flag_mismatch($sformatf("addr=%h, want %h (found=%0b)", addr, want.addr, want.found));
      if (want.found) hits++;
      else misses++;
    endtask

    function int unsigned pending();
      return pending_matches.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [BYTE_W-1:0]     s_axis_tdata_i;
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [ADDR_W-1:0]     m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  match_tracker tracker;

  // Register image that the stimulus loads and plants patterns from
  logic [8*REG_BYTES-1:0] cfg_pat;
  logic [23:0]            cfg_care;
  logic [PLEN_W-1:0]      cfg_plen;
  logic [ADDR_W-1:0]      cfg_base;
  logic [31:0]            cfg_scan;

  bit          snd_idle_en;
  bit          rcv_idle_en;
  bit          hold_off_req;
  int unsigned bytes_sent;
  int unsigned scans_sent;
  int unsigned settings_loaded;
  int unsigned quiet_cycles;

  masked_byte_pattern_search_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 50 MHz clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Observe every request on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o)
        tracker.write_reg(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o)
        tracker.take_byte(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracker.check_match(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  // Abort when no request moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, tracker.pending());
      $display("masked_byte_pattern_search_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random back-pressure plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= !(rcv_idle_en && $urandom_range(99) < 13);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] d, input bit last);
    while (snd_idle_en && $urandom_range(99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Send n bytes, lowest byte first, with tlast on the final one.
  task automatic send_run(input logic [63:0] bytes, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_byte(bytes[i*8 +: 8], i == n - 1);
    scans_sent++;
  endtask

  // One scan of n bytes; optionally plant the pattern at a random offset.
  task automatic send_scan(input int unsigned n, input bit plant);
    int unsigned len;
    int unsigned at;
    int unsigned i;
    logic [7:0]  b;
    len = tracker.eff_len();
    at  = (plant && n >= len) ? $urandom_range(n - len) : n;
    for (i = 0; i < n; i++) begin
      if (i >= at && i < at + len && cfg_care[i-at])
        b = cfg_pat[(i-at)*8 +: 8];
      else if ($urandom_range(1) == 0)
        b = cfg_pat[$urandom_range(REG_BYTES - 1)*8 +: 8];
      else
        b = 8'($urandom_range(255));
      send_byte(b, i == n - 1);
    end
    scans_sent++;
  endtask

  // Drop the input, let all results drain and the last byte retire.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write all registers from the image; unused upper data bits carry junk.
  task automatic load_config();
    write_reg(REG_PAT_LOW,  cfg_pat[63:0]);
    write_reg(REG_PAT_MID,  cfg_pat[127:64]);
    write_reg(REG_PAT_HIGH, cfg_pat[191:128]);
    write_reg(REG_CARE,     {$urandom, 8'($urandom), cfg_care});
    write_reg(REG_PLEN,     {$urandom, 27'($urandom), cfg_plen});
    write_reg(REG_BASE,     {$urandom, cfg_base});
    write_reg(REG_SCAN_LEN, {$urandom, cfg_scan});
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  // Random settings with the extremes weighted in
  task automatic pick_config();
    cfg_pat = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(5))
      0:       cfg_care = '0;
      1:       cfg_care = '1;
      default: cfg_care = 24'($urandom);
    endcase
    case ($urandom_range(9))
      0:       cfg_plen = '0;
      1:       cfg_plen = PLEN_W'(PATTERN_MAX);
      2:       cfg_plen = PLEN_W'($urandom_range(PATTERN_MAX + 1, 31));
      3:       cfg_plen = PLEN_W'($urandom_range(9, PATTERN_MAX - 1));
      default: cfg_plen = PLEN_W'($urandom_range(1, 8));
    endcase
    cfg_base = ($urandom_range(3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom;
    case ($urandom_range(5))
      0:       cfg_scan = '0;
      1:       cfg_scan = '1;
      2:       cfg_scan = 1;
      default: cfg_scan = $urandom_range(1, 40);
    endcase
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_start;
    bit          pressure;
    tracker         = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_PAT_LOW;
    cfg_data_i      = '0;
    snd_idle_en     = 1'b1;
    rcv_idle_en     = 1'b1;
    hold_off_req    = 1'b0;
    bytes_sent      = 0;
    scans_sent      = 0;
    settings_loaded = 0;
    quiet_cycles    = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Exact three-byte pattern with 'x' in it, base at the top of the range.
    cfg_pat  = {$urandom, $urandom, $urandom, $urandom, $urandom, 8'($urandom), 24'h78FF00};
    cfg_care = '1;
    cfg_plen = PLEN_W'(3);
    cfg_base = 32'hFFFF_FFFF;
    cfg_scan = '1;
    load_config();
    // First match at offset 1 wraps the address; the repeat is ignored.
    send_run(64'h55_78_FF_00_78_FF_00_11, 8);
    // Match on the last byte reports found only.
    send_run(64'h78_FF_00, 3);
    // Scan shorter than the pattern ends not found.
    send_run(64'hFF, 1);

    // Match starts right at the scan length limit: not counted.
    wait_idle();
    cfg_scan = 2;
    load_config();
    send_run(64'h78_FF_00_00_00, 5);

    // Zero length acts as one; zero scan length allows no match.
    wait_idle();
    cfg_plen = '0;
    cfg_care = '0;
    cfg_scan = '0;
    cfg_base = '0;
    load_config();
    send_run(64'h34_12, 2);

    // Single cared byte on zero length.
    wait_idle();
    cfg_care = 24'h000001;
    cfg_pat[7:0] = 8'h78;
    cfg_scan = '1;
    load_config();
    send_run(64'h78_AB, 2);

    // Random settings, one phase without idling and one with a long hold-off.
    phase      = 0;
    bytes_sent = 0;
    while (bytes_sent < TARGET_BYTES) begin
      wait_idle();
      pick_config();
      pressure    = (phase == 5);
      snd_idle_en = (phase != 2);
      rcv_idle_en = (phase != 2);
      if (pressure) cfg_scan = '1;
      load_config();
      if (pressure) hold_off_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if (pressure)
          send_scan($urandom_range(1, 3), 1'b1);
        else
          send_scan($urandom_range(1, tracker.eff_len() + 16), $urandom_range(3) != 0);
      end
      phase++;
    end

    wait_idle();
    repeat (SETTLE) @(negedge clk_i);
    $display("Covered %0d scans over %0d register settings, including wrap and hold-off.",
             scans_sent, settings_loaded);
    $display("Checked %0d found and %0d not-found results, %0d mismatches.",
             tracker.hits, tracker.misses, tracker.errors);
    if (tracker.errors == 0) begin
      $display("masked_byte_pattern_search_core: match");
    end else begin
      $display("masked_byte_pattern_search_core: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_cell.sv
sv/mbps_out_buf.sv
sv/masked_byte_pattern_search_core.sv
sv/mbps_checker.sv
bench/masked_byte_pattern_search_core_tb.sv
